// File: src/rmd_pkg.sv
// ----------------------------------------------------------------------------
// rmd_pkg: shared definitions for the reduce method decompressor
// Sizes, codes and the command and status records between controller and
// datapath.
// ----------------------------------------------------------------------------
package rmd_pkg;

  localparam int HISTORY_DEPTH = 16384;
  localparam int MAX_SET_SIZE  = 64;
  localparam int NUM_SETS      = 256;

  localparam int HIST_AW = $clog2(HISTORY_DEPTH);
  localparam int SET_AW  = $clog2(NUM_SETS);
  localparam int ENT_AW  = $clog2(MAX_SET_SIZE);
  localparam int FOL_AW  = SET_AW + ENT_AW;

  localparam logic [7:0]  ESC_BYTE  = 8'd144;
  localparam logic [13:0] DIST_MASK = 14'h3fff;

  // Bytes one input item may produce before decoding pauses.
  localparam logic [8:0] STEP_BYTES = 9'd392;

  // Configuration register indexes.
  localparam logic CFG_IDX_FACTOR = 1'b0;
  localparam logic CFG_IDX_LIMIT  = 1'b1;

  typedef enum logic [1:0] {
    LD_COUNT,
    LD_BYTES,
    LD_DONE
  } load_phase_e;

  typedef enum logic [1:0] {
    ESC_PLAIN,
    ESC_SEEN,
    ESC_EXTRA,
    ESC_DIST
  } esc_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_STOP,
    OP_COPY,
    OP_LOAD,
    OP_DECODE,
    OP_FOL_CAP,
    OP_SYM,
    OP_FLUSH
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ITER,
    ST_COPY,
    ST_SIZE,
    ST_DECODE,
    ST_FOL,
    ST_SYM,
    ST_FLUSH
  } ctrl_state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic limit_hit;
    logic copy_pending;
    logic loading;
    logic load_ready;
    logic budget_full;
    logic dec_ok;
    logic dec_index;
    logic sym_emits;
    logic pack_full;
    logic pack_nonempty;
    logic out_free;
  } status_t;

endpackage

// File: src/rmd_ram.sv
// ----------------------------------------------------------------------------
// rmd_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rmd_ctrl.sv
// ----------------------------------------------------------------------------
// rmd_ctrl: decoding sequencer
// Walks the decode loop for one input item and issues datapath commands.
// ----------------------------------------------------------------------------
module rmd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rmd_pkg::status_t status_i,
  output rmd_pkg::cmd_t    cmd_o
);
  import rmd_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = ST_ITER;
        end
      end
      ST_ITER: begin
        if (status_i.limit_hit) begin
          cmd_o.op = OP_STOP;
          state_d  = ST_FLUSH;
        end else if (status_i.copy_pending) begin
          state_d = status_i.budget_full ? ST_FLUSH : ST_COPY;
        end else if (status_i.loading) begin
          if (status_i.load_ready) begin
            cmd_o.op = OP_LOAD;
          end else begin
            state_d = ST_FLUSH;
          end
        end else begin
          state_d = status_i.budget_full ? ST_FLUSH : ST_SIZE;
        end
      end
      ST_COPY: begin
        if (!(status_i.pack_full && !status_i.out_free)) begin
          cmd_o.op = OP_COPY;
          state_d  = ST_ITER;
        end
      end
      ST_SIZE: begin
        state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (!status_i.dec_ok) begin
          state_d = ST_FLUSH;
        end else begin
          cmd_o.op = OP_DECODE;
          state_d  = status_i.dec_index ? ST_FOL : ST_SYM;
        end
      end
      ST_FOL: begin
        cmd_o.op = OP_FOL_CAP;
        state_d  = ST_SYM;
      end
      ST_SYM: begin
        if (!(status_i.sym_emits && status_i.pack_full && !status_i.out_free)) begin
          cmd_o.op = OP_SYM;
          state_d  = ST_ITER;
        end
      end
      ST_FLUSH: begin
        if (!status_i.pack_nonempty) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.op = OP_FLUSH;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: src/rmd_dpath.sv
// ----------------------------------------------------------------------------
// rmd_dpath: decompressor datapath
// Bit buffer, follower set tables, escape decoding, history copy and the
// output packer with its output register.
// ----------------------------------------------------------------------------
module rmd_dpath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_sos_i,
  input  logic             in_final_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [63:0]      out_bytes_o,
  output logic [3:0]       out_count_o,
  output logic             out_last_o,
  output logic             out_limit_o,
  input  rmd_pkg::cmd_t    cmd_i,
  output rmd_pkg::status_t status_o
);
  import rmd_pkg::*;

  // Smallest index width that covers a set of n entries.
  function automatic logic [2:0] index_width(input logic [5:0] n);
    logic [2:0] b;
    b = 3'd1;
    for (int k = 1; k < 8; k++) begin
      if ((9'd1 << k) < {3'b0, n}) b = 3'(k + 1);
    end
    return b;
  endfunction

  logic [2:0]         factor_q, factor_d;
  logic [31:0]        limit_q, limit_d;
  logic [31:0]        buf_q, buf_d;
  logic [5:0]         cnt_q, cnt_d;
  load_phase_e        phase_q, phase_d;
  logic [SET_AW-1:0]  set_q, set_d;
  logic [ENT_AW-1:0]  entry_q, entry_d;
  logic [5:0]         cur_size_q, cur_size_d;
  logic [7:0]         prev_q, prev_d;
  esc_state_e         esc_q, esc_d;
  logic [7:0]         lc_q, lc_d;
  logic [8:0]         ml_q, ml_d;
  logic [31:0]        bw_q, bw_d;
  logic [8:0]         copy_left_q, copy_left_d;
  logic [13:0]        dist_q, dist_d;
  logic [HIST_AW-1:0] pos_q, pos_d;
  logic               closed_q, closed_d;
  logic [8:0]         step_n_q, step_n_d;
  logic [7:0]         sym_q, sym_d;
  logic               idx_ok_q, idx_ok_d;
  logic [63:0]        pack_q, pack_d;
  logic [3:0]         pack_cnt_q, pack_cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [63:0]        out_bytes_q, out_bytes_d;
  logic [3:0]         out_count_q, out_count_d;
  logic               out_last_q, out_last_d;
  logic               out_limit_q, out_limit_d;

  // Memory ports.
  logic               size_we;
  logic [5:0]         size_rdata;
  logic               fol_we;
  logic [FOL_AW-1:0]  fol_waddr, fol_raddr;
  logic [7:0]         fol_rdata;
  logic               hist_we;
  logic [HIST_AW-1:0] hist_raddr;
  logic [7:0]         hist_rdata;
  logic [7:0]         put_byte;
  logic               put_en;

  // Decode view of the buffer for the current follower set size.
  logic [2:0]         idx_w;
  logic [3:0]         need;
  logic [7:0]         idx8;
  logic [7:0]         raw_sym;
  logic               dec_index;
  logic               src_zero;
  logic [15:0]        hp16, d16, hr16;

  assign idx_w     = index_width(size_rdata);
  assign dec_index = (size_rdata != 6'd0) && !buf_q[0];
  assign need      = (size_rdata == 6'd0) ? 4'd8 : (buf_q[0] ? 4'd9 : 4'({1'b0, idx_w} + 4'd1));
  assign idx8      = buf_q[8:1] & ((8'd1 << idx_w) - 8'd1);
  assign raw_sym   = (size_rdata == 6'd0) ? buf_q[7:0] : buf_q[8:1];
  assign fol_raddr = {prev_q, idx8[ENT_AW-1:0]};

  // History read address for the pending copy.
  assign hp16       = 16'(pos_q);
  assign d16        = 16'(dist_q);
  assign hr16       = (hp16 >= d16) ? (hp16 - d16) : (hp16 + 16'(HISTORY_DEPTH) - d16);
  assign hist_raddr = hr16[HIST_AW-1:0];
  assign src_zero   = (dist_q == 14'd0) || ({18'b0, dist_q} > bw_q) ||
                      ({2'b0, dist_q} > 16'(HISTORY_DEPTH));

  // Status toward the controller.
  always_comb begin
    status_o.limit_hit     = bw_q >= limit_q;
    status_o.copy_pending  = copy_left_q != 9'd0;
    status_o.loading       = phase_q != LD_DONE;
    status_o.load_ready    = (phase_q == LD_COUNT) ? (cnt_q >= 6'd6) : (cnt_q >= 6'd8);
    status_o.budget_full   = step_n_q >= STEP_BYTES;
    status_o.dec_ok        = cnt_q >= {2'b0, need};
    status_o.dec_index     = dec_index;
    status_o.sym_emits     = ((esc_q == ESC_PLAIN) && (sym_q != ESC_BYTE)) ||
                             ((esc_q == ESC_SEEN) && (sym_q == 8'd0));
    status_o.pack_full     = pack_cnt_q == 4'd8;
    status_o.pack_nonempty = pack_cnt_q != 4'd0;
    status_o.out_free      = !out_valid_q || out_ready_i;
  end

  // Next state for all commands.
  always_comb begin
    logic [2:0]  f;
    logic [7:0]  low_mask;
    logic [7:0]  hi;
    logic [12:0] dist13;
    logic        clr_closed;
    logic [5:0]  cnt_e;
    logic [31:0] buf_e;
    logic [6:0]  entry_nx;
    logic [7:0]  fol_sym;

    factor_d    = factor_q;
    limit_d     = limit_q;
    buf_d       = buf_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    set_d       = set_q;
    entry_d     = entry_q;
    cur_size_d  = cur_size_q;
    prev_d      = prev_q;
    esc_d       = esc_q;
    lc_d        = lc_q;
    ml_d        = ml_q;
    bw_d        = bw_q;
    copy_left_d = copy_left_q;
    dist_d      = dist_q;
    pos_d       = pos_q;
    closed_d    = closed_q;
    step_n_d    = step_n_q;
    sym_d       = sym_q;
    idx_ok_d    = idx_ok_q;
    pack_d      = pack_q;
    pack_cnt_d  = pack_cnt_q;
    out_bytes_d = out_bytes_q;
    out_count_d = out_count_q;
    out_last_d  = out_last_q;
    out_limit_d = out_limit_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    size_we     = 1'b0;
    fol_we      = 1'b0;
    fol_waddr   = {set_q, entry_q};
    put_en      = 1'b0;
    put_byte    = 8'd0;

    f = factor_q;
    if (f == 3'd0) f = 3'd1;
    if (f > 3'd4) f = 3'd4;
    low_mask = (8'd1 << (4'd8 - {1'b0, f})) - 8'd1;
    hi       = lc_q >> (4'd8 - {1'b0, f});
    dist13   = {1'b0, hi[3:0], 8'd0} + {5'd0, sym_q} + 13'd1;
    entry_nx = {1'b0, entry_q} + 7'd1;
    fol_sym  = idx_ok_q ? fol_rdata : 8'd0;
    clr_closed = closed_q;
    cnt_e      = cnt_q;
    buf_e      = buf_q;

    // Configuration writes.
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_FACTOR: factor_d = cfg_data_i[2:0];
        default:        limit_d  = cfg_data_i;
      endcase
    end

    case (cmd_i.op)
      OP_ACCEPT: begin
        if (in_sos_i) begin
          phase_d     = LD_COUNT;
          set_d       = SET_AW'(NUM_SETS - 1);
          entry_d     = '0;
          prev_d      = 8'd0;
          esc_d       = ESC_PLAIN;
          lc_d        = 8'd0;
          ml_d        = 9'd0;
          bw_d        = 32'd0;
          copy_left_d = 9'd0;
          dist_d      = 14'd0;
          pos_d       = '0;
          clr_closed  = 1'b0;
          cnt_e       = 6'd0;
          buf_e       = 32'd0;
        end
        buf_d    = buf_e;
        cnt_d    = cnt_e;
        closed_d = clr_closed;
        if (!clr_closed) begin
          if (cnt_e <= 6'd24) begin
            buf_d = buf_e | ({24'd0, in_byte_i} << cnt_e[4:0]);
            cnt_d = cnt_e + 6'd8;
          end
          if (in_final_i) closed_d = 1'b1;
        end
        step_n_d = 9'd0;
      end
      OP_STOP: begin
        buf_d       = 32'd0;
        cnt_d       = 6'd0;
        copy_left_d = 9'd0;
        closed_d    = 1'b1;
      end
      OP_COPY: begin
        put_en      = 1'b1;
        put_byte    = src_zero ? 8'd0 : hist_rdata;
        copy_left_d = copy_left_q - 9'd1;
      end
      OP_LOAD: begin
        if (phase_q == LD_COUNT) begin
          size_we    = 1'b1;
          cur_size_d = buf_q[5:0];
          entry_d    = '0;
          buf_d      = buf_q >> 6;
          cnt_d      = cnt_q - 6'd6;
          if (buf_q[5:0] == 6'd0) begin
            if (set_q == '0) phase_d = LD_DONE;
            else begin
              set_d   = set_q - 1'b1;
              phase_d = LD_COUNT;
            end
          end else begin
            phase_d = LD_BYTES;
          end
        end else begin
          fol_we  = 1'b1;
          entry_d = entry_nx[ENT_AW-1:0];
          buf_d   = buf_q >> 8;
          cnt_d   = cnt_q - 6'd8;
          if (entry_nx >= {1'b0, cur_size_q}) begin
            if (set_q == '0) phase_d = LD_DONE;
            else begin
              set_d   = set_q - 1'b1;
              phase_d = LD_COUNT;
            end
          end
        end
      end
      OP_DECODE: begin
        buf_d = buf_q >> need;
        cnt_d = cnt_q - {2'b0, need};
        if (dec_index) begin
          idx_ok_d = idx8 < {2'b0, size_rdata};
        end else begin
          sym_d  = raw_sym;
          prev_d = raw_sym;
        end
      end
      OP_FOL_CAP: begin
        sym_d  = fol_sym;
        prev_d = fol_sym;
      end
      OP_SYM: begin
        case (esc_q)
          ESC_PLAIN: begin
            if (sym_q != ESC_BYTE) begin
              put_en   = 1'b1;
              put_byte = sym_q;
            end else begin
              esc_d = ESC_SEEN;
            end
          end
          ESC_SEEN: begin
            if (sym_q != 8'd0) begin
              lc_d  = sym_q;
              ml_d  = {1'b0, sym_q & low_mask};
              esc_d = ((sym_q & low_mask) == low_mask) ? ESC_EXTRA : ESC_DIST;
            end else begin
              put_en   = 1'b1;
              put_byte = ESC_BYTE;
              esc_d    = ESC_PLAIN;
            end
          end
          ESC_EXTRA: begin
            ml_d  = ml_q + {1'b0, sym_q};
            esc_d = ESC_DIST;
          end
          default: begin
            dist_d      = {1'b0, dist13} & DIST_MASK;
            copy_left_d = ml_q + 9'd3;
            esc_d       = ESC_PLAIN;
          end
        endcase
      end
      OP_FLUSH: begin
        out_valid_d = 1'b1;
        out_bytes_d = pack_q;
        out_count_d = pack_cnt_q;
        out_last_d  = 1'b1;
        out_limit_d = bw_q >= limit_q;
        pack_d      = 64'd0;
        pack_cnt_d  = 4'd0;
      end
      default: ;
    endcase

    // One output byte: history, counters and the packer.
    if (put_en) begin
      pos_d    = (pos_q == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : pos_q + 1'b1;
      bw_d     = bw_q + 32'd1;
      step_n_d = step_n_q + 9'd1;
      if (pack_cnt_q == 4'd8) begin
        out_valid_d = 1'b1;
        out_bytes_d = pack_q;
        out_count_d = pack_cnt_q;
        out_last_d  = 1'b0;
        out_limit_d = bw_q >= limit_q;
        pack_d      = {56'd0, put_byte};
        pack_cnt_d  = 4'd1;
      end else begin
        pack_d                      = pack_q;
        pack_d[pack_cnt_q[2:0]*8 +: 8] = put_byte;
        pack_cnt_d                  = pack_cnt_q + 4'd1;
      end
    end
    hist_we = put_en;
  end

  // State registers. The packer starts out zero so unused bytes read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q    <= 3'd1;
      limit_q     <= 32'hffff_ffff;
      buf_q       <= 32'd0;
      cnt_q       <= 6'd0;
      phase_q     <= LD_COUNT;
      set_q       <= SET_AW'(NUM_SETS - 1);
      entry_q     <= '0;
      cur_size_q  <= 6'd0;
      prev_q      <= 8'd0;
      esc_q       <= ESC_PLAIN;
      lc_q        <= 8'd0;
      ml_q        <= 9'd0;
      bw_q        <= 32'd0;
      copy_left_q <= 9'd0;
      dist_q      <= 14'd0;
      pos_q       <= '0;
      closed_q    <= 1'b0;
      step_n_q    <= 9'd0;
      idx_ok_q    <= 1'b0;
      pack_q      <= 64'd0;
      pack_cnt_q  <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      factor_q    <= factor_d;
      limit_q     <= limit_d;
      buf_q       <= buf_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      set_q       <= set_d;
      entry_q     <= entry_d;
      cur_size_q  <= cur_size_d;
      prev_q      <= prev_d;
      esc_q       <= esc_d;
      lc_q        <= lc_d;
      ml_q        <= ml_d;
      bw_q        <= bw_d;
      copy_left_q <= copy_left_d;
      dist_q      <= dist_d;
      pos_q       <= pos_d;
      closed_q    <= closed_d;
      step_n_q    <= step_n_d;
      idx_ok_q    <= idx_ok_d;
      pack_q      <= pack_d;
      pack_cnt_q  <= pack_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sym_q       <= sym_d;
    out_bytes_q <= out_bytes_d;
    out_count_q <= out_count_d;
    out_last_q  <= out_last_d;
    out_limit_q <= out_limit_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_bytes_o = out_bytes_q;
  assign out_count_o = out_count_q;
  assign out_last_o  = out_last_q;
  assign out_limit_o = out_limit_q;

  // Follower set sizes.
  rmd_ram #(.WIDTH(6), .DEPTH(NUM_SETS)) u_sizes (
    .clk_i   (clk_i),
    .we_i    (size_we),
    .waddr_i (set_q),
    .wdata_i (buf_q[5:0]),
    .raddr_i (prev_q),
    .rdata_o (size_rdata)
  );

  // Follower set entries.
  rmd_ram #(.WIDTH(8), .DEPTH(NUM_SETS * MAX_SET_SIZE)) u_followers (
    .clk_i   (clk_i),
    .we_i    (fol_we),
    .waddr_i (fol_waddr),
    .wdata_i (buf_q[7:0]),
    .raddr_i (fol_raddr),
    .rdata_o (fol_rdata)
  );

  // Output history.
  rmd_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_history (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (pos_q),
    .wdata_i (put_byte),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

endmodule

// File: src/reduce_method_decompressor.sv
// ----------------------------------------------------------------------------
// reduce_method_decompressor: reduce method expander
// Sequence: an item is taken in IDLE; each follower set count or byte is then
// loaded from ITER, each symbol passes SIZE, DECODE, FOL when indexed, and SYM,
// and each copied byte goes through ITER and COPY. Throughput: one item at a
// time, set by the decode sequencer and the single history read port.
// Reset: asynchronous and active low; clears all control state. The history
// and follower tables are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module reduce_method_decompressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // Compressed input.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
  input  logic        s_axis_tlast,   // final_byte
  input  logic        s_axis_tuser,   // start_of_stream
  // Decompressed output.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_bytes[63:0], byte_count[67:64], zero pad
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser    // limit_reached
);
  import rmd_pkg::*;

  cmd_t        cmd;
  status_t     status;
  logic [63:0] out_bytes;
  logic [3:0]  out_count;

  // Sequencer.
  rmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  rmd_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_byte_i   (s_axis_tdata),
    .in_sos_i    (s_axis_tuser),
    .in_final_i  (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_bytes_o (out_bytes),
    .out_count_o (out_count),
    .out_last_o  (m_axis_tlast),
    .out_limit_o (m_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // Pack the result fields.
  assign m_axis_tdata = {4'd0, out_count, out_bytes};

endmodule
